>>> rtl/gspi_pkg.sv
// ----------------------------------------------------------------------------
// gspi_pkg: shared types and constants of the gain-scheduled PI speed loop
// Fixed-point widths, command and range codes, configuration register indexes
// and the sequencer step type.
// ----------------------------------------------------------------------------
package gspi_pkg;

  // Integrator fraction bits; the integrator gain registers are scaled by 2^this.
  localparam int INT_FRAC_BITS = 40;
  localparam int INT_W         = 64;
  localparam int IH_SHIFT      = INT_FRAC_BITS - 16;
  localparam int IH_W          = INT_W - IH_SHIFT;

  localparam int SPEED_W = 16;
  localparam int TICKS_W = 16;
  localparam int KP_W    = 12;
  localparam int KI_W    = 20;
  localparam int TW_W    = 16;
  localparam int DRIVE_W = 9;
  localparam int RANGE_W = 2;
  localparam int CMD_W   = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Datapath widths
  localparam int ERR_W  = SPEED_W + 1;               // target - measured
  localparam int ERRP_W = 34;                        // target*alpha - measured*256
  localparam int P_W    = ERRP_W + KP_W;             // kp * errp
  localparam int ACC_W  = KI_W + ERR_W + TICKS_W + 1; // ki * err * ticks, signed
  localparam int MA_W   = 38;                        // multiplier signed operand
  localparam int MB_W   = 20;                        // multiplier unsigned operand
  localparam int MP_W   = MA_W + MB_W + 1;
  localparam int X_W    = ((IH_W > P_W) ? IH_W : P_W) + 1;
  localparam int FL_W   = X_W - 16;

  localparam int DRIVE_LIMIT = 200;

  localparam logic signed [SPEED_W-1:0] SPD_HIGH_POS = 16'sd150;
  localparam logic signed [SPEED_W-1:0] SPD_HIGH_NEG = -16'sd200;
  localparam logic signed [SPEED_W-1:0] SPD_MID_POS  = 16'sd40;
  localparam logic signed [SPEED_W-1:0] SPD_MID_NEG  = -16'sd40;

  localparam logic [KP_W-1:0] KP_MID_RST   = 12'd307;
  localparam logic [KP_W-1:0] KP_HIGH_RST  = 12'd806;
  localparam logic [KP_W-1:0] KP_LOW_RST   = 12'd205;
  localparam logic [KI_W-1:0] KI_MID_RST   = 20'd98956;
  localparam logic [KI_W-1:0] KI_HIGH_RST  = 20'd109951;
  localparam logic [KI_W-1:0] KI_LOW_RST   = 20'd131941;
  localparam logic [TW_W-1:0] TW_RST       = 16'd256;

  localparam logic [CMD_W-1:0] CMD_SET_TARGET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_MEASURED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE      = 2'd2;

  localparam logic [RANGE_W-1:0] RANGE_MID  = 2'd0;
  localparam logic [RANGE_W-1:0] RANGE_HIGH = 2'd1;
  localparam logic [RANGE_W-1:0] RANGE_LOW  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KP_MID        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_HIGH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_LOW        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_MID        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_HIGH       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_LOW        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WEIGHT = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_TW,
    ST_DIFF,
    ST_MUL_KP,
    ST_MUL_KI,
    ST_MUL_TK,
    ST_INTEG,
    ST_SUM,
    ST_FINISH
  } step_t;

  typedef struct packed {
    step_t step;
    logic  in_load;
    logic  out_load;
  } ctl_t;

endpackage

>>> rtl/gspi_if.sv
// ----------------------------------------------------------------------------
// gspi_if: valid/ready channels of the speed controller
// Command channel into the block and drive result channel out of it.
// ----------------------------------------------------------------------------
interface gspi_in_if;
  logic                                valid;
  logic                                ready;
  logic [gspi_pkg::CMD_W-1:0]          command;
  logic signed [gspi_pkg::SPEED_W-1:0] speed;
  logic [gspi_pkg::TICKS_W-1:0]        elapsed_ticks;

  modport source (output valid, command, speed, elapsed_ticks, input ready);
  modport sink   (input valid, command, speed, elapsed_ticks, output ready);
endinterface

interface gspi_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [gspi_pkg::DRIVE_W-1:0] drive;
  logic [gspi_pkg::RANGE_W-1:0]        gain_set;

  modport source (output valid, drive, gain_set, input ready);
  modport sink   (input valid, drive, gain_set, output ready);
endinterface

>>> rtl/gspi_mul.sv
// ----------------------------------------------------------------------------
// gspi_mul: shared signed-by-unsigned multiplier
// The one multiplier of the block; every product of a compute goes through it.
// ----------------------------------------------------------------------------
module gspi_mul (
  input  logic signed [gspi_pkg::MA_W-1:0] a,
  input  logic        [gspi_pkg::MB_W-1:0] b,
  output logic signed [gspi_pkg::MP_W-1:0] p
);

  logic signed [gspi_pkg::MB_W:0] b_s;

  assign b_s = $signed({1'b0, b});
  assign p   = gspi_pkg::MP_W'(a) * gspi_pkg::MP_W'(b_s);

endmodule

>>> rtl/gspi_seq.sv
// ----------------------------------------------------------------------------
// gspi_seq: step sequencer of the speed controller
// Walks a compute through the shared multiplier steps and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module gspi_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [gspi_pkg::CMD_W-1:0] in_command,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output gspi_pkg::ctl_t             ctl
);

  gspi_pkg::step_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            slot_free;

  assign in_ready  = (state_r == gspi_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gspi_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl.step      = state_r;
    ctl.in_load   = accept;
    ctl.out_load  = 1'b0;
    unique case (state_r)
      gspi_pkg::ST_IDLE: begin
        if (accept && in_command == gspi_pkg::CMD_COMPUTE) begin
          state_nxt = gspi_pkg::ST_MUL_TW;
        end
      end
      gspi_pkg::ST_MUL_TW: state_nxt = gspi_pkg::ST_DIFF;
      gspi_pkg::ST_DIFF:   state_nxt = gspi_pkg::ST_MUL_KP;
      gspi_pkg::ST_MUL_KP: state_nxt = gspi_pkg::ST_MUL_KI;
      gspi_pkg::ST_MUL_KI: state_nxt = gspi_pkg::ST_MUL_TK;
      gspi_pkg::ST_MUL_TK: state_nxt = gspi_pkg::ST_INTEG;
      gspi_pkg::ST_INTEG:  state_nxt = gspi_pkg::ST_SUM;
      gspi_pkg::ST_SUM:    state_nxt = gspi_pkg::ST_FINISH;
      gspi_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (slot_free) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = gspi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gspi_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/gspi_dp.sv
// ----------------------------------------------------------------------------
// gspi_dp: datapath of the speed controller
// Gain registers, speeds, integrators, the shared multiplier with its operand
// selection, saturating integrator update and drive rounding and clamping.
// ----------------------------------------------------------------------------
module gspi_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gspi_pkg::ctl_t                       ctl,
  input  logic                                 cfg_we,
  input  logic [gspi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gspi_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [gspi_pkg::CMD_W-1:0]           in_command,
  input  logic signed [gspi_pkg::SPEED_W-1:0]  in_speed,
  input  logic [gspi_pkg::TICKS_W-1:0]         in_elapsed_ticks,
  output logic signed [gspi_pkg::DRIVE_W-1:0]  out_drive,
  output logic [gspi_pkg::RANGE_W-1:0]         out_gain_set
);

  localparam int INT_W  = gspi_pkg::INT_W;
  localparam int SH     = gspi_pkg::IH_SHIFT;
  localparam int X_W    = gspi_pkg::X_W;
  localparam int FL_W   = gspi_pkg::FL_W;
  localparam int ACC_W  = gspi_pkg::ACC_W;
  localparam int MA_W   = gspi_pkg::MA_W;
  localparam int MB_W   = gspi_pkg::MB_W;
  localparam int P_W    = gspi_pkg::P_W;
  localparam int ERR_W  = gspi_pkg::ERR_W;
  localparam int ERRP_W = gspi_pkg::ERRP_W;
  localparam int IH_W   = gspi_pkg::IH_W;
  localparam int SPD_W  = gspi_pkg::SPEED_W;

  localparam logic signed [FL_W-1:0] FL_MAX = FL_W'(gspi_pkg::DRIVE_LIMIT);
  localparam logic signed [FL_W-1:0] FL_MIN = -FL_MAX;
  localparam logic signed [gspi_pkg::DRIVE_W-1:0] DRV_MAX =
    gspi_pkg::DRIVE_W'(gspi_pkg::DRIVE_LIMIT);
  localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
  localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

  // Configuration registers
  logic [gspi_pkg::KP_W-1:0] kp_mid_r, kp_high_r, kp_low_r;
  logic [gspi_pkg::KI_W-1:0] ki_mid_r, ki_high_r, ki_low_r;
  logic [gspi_pkg::TW_W-1:0] tw_r;

  // Architectural state
  logic signed [SPD_W-1:0]         target_r, measured_r;
  logic signed [INT_W-1:0]         integ_r [3];
  logic [gspi_pkg::RANGE_W-1:0]    range_r;

  // Work registers of one compute
  logic [gspi_pkg::TICKS_W-1:0]    ticks_r;
  logic signed [ACC_W-1:0]         acc_r;
  logic signed [ERRP_W-1:0]        errp_r;
  logic signed [ERR_W-1:0]         err_r;
  logic signed [P_W-1:0]           p_r;
  logic signed [X_W-1:0]           x_r;
  logic                            fz_r;
  logic signed [gspi_pkg::DRIVE_W-1:0] drive_r;
  logic [gspi_pkg::RANGE_W-1:0]    gain_set_r;

  logic signed [MA_W-1:0]          mul_a;
  logic [MB_W-1:0]                 mul_b;
  logic signed [gspi_pkg::MP_W-1:0] mul_p;

  logic [1:0]                      rsel;
  logic [gspi_pkg::KP_W-1:0]       kp_sel;
  logic [gspi_pkg::KI_W-1:0]       ki_sel;
  logic signed [INT_W-1:0]         integ_sel, inc64, integ_sum, integ_new;
  logic                            integ_ovf;
  logic signed [IH_W-1:0]          ih;
  logic signed [ERRP_W-1:0]        meas_q8;
  logic signed [FL_W-1:0]          fl, drv_w;
  logic                            round_up;
  logic signed [gspi_pkg::DRIVE_W-1:0] drv_clamped;
  logic [gspi_pkg::RANGE_W-1:0]    range_pick;

  // Select the active gain set
  always_comb begin
    unique case (range_r)
      gspi_pkg::RANGE_HIGH: begin
        rsel = 2'd1; kp_sel = kp_high_r; ki_sel = ki_high_r;
      end
      gspi_pkg::RANGE_LOW: begin
        rsel = 2'd2; kp_sel = kp_low_r;  ki_sel = ki_low_r;
      end
      default: begin
        rsel = 2'd0; kp_sel = kp_mid_r;  ki_sel = ki_mid_r;
      end
    endcase
  end

  assign integ_sel = integ_r[rsel];

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.step)
      gspi_pkg::ST_MUL_TW: begin
        mul_a = MA_W'(target_r);
        mul_b = MB_W'(tw_r);
      end
      gspi_pkg::ST_MUL_KP: begin
        mul_a = MA_W'(errp_r);
        mul_b = MB_W'(kp_sel);
      end
      gspi_pkg::ST_MUL_KI: begin
        mul_a = MA_W'(err_r);
        mul_b = MB_W'(ki_sel);
      end
      gspi_pkg::ST_MUL_TK: begin
        mul_a = acc_r[MA_W-1:0];
        mul_b = MB_W'(ticks_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  gspi_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  // Saturating integrator update
  assign inc64     = INT_W'(acc_r);
  assign integ_sum = integ_sel + inc64;
  assign integ_ovf = (integ_sel[INT_W-1] == inc64[INT_W-1]) &&
                     (integ_sum[INT_W-1] != integ_sel[INT_W-1]);
  assign integ_new = integ_ovf ? (integ_sel[INT_W-1] ? INT_MIN : INT_MAX) : integ_sum;

  assign ih      = integ_sel[INT_W-1:SH];
  assign meas_q8 = ERRP_W'(measured_r) <<< 8;

  // Truncate toward zero: floor plus one when negative and inexact
  assign fl       = x_r[X_W-1:16];
  assign round_up = fl[FL_W-1] && !(fz_r && (x_r[15:0] == '0));
  assign drv_w    = fl + FL_W'({1'b0, round_up});

  always_comb begin
    if (drv_w >= FL_MAX) begin
      drv_clamped = DRV_MAX;
    end else if (drv_w <= FL_MIN) begin
      drv_clamped = -DRV_MAX;
    end else begin
      drv_clamped = drv_w[gspi_pkg::DRIVE_W-1:0];
    end
  end

  // Range choice from a new target
  always_comb begin
    if (in_speed > gspi_pkg::SPD_HIGH_POS || in_speed < gspi_pkg::SPD_HIGH_NEG) begin
      range_pick = gspi_pkg::RANGE_HIGH;
    end else if (in_speed > gspi_pkg::SPD_MID_POS || in_speed < gspi_pkg::SPD_MID_NEG) begin
      range_pick = gspi_pkg::RANGE_MID;
    end else begin
      range_pick = gspi_pkg::RANGE_LOW;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_mid_r  <= gspi_pkg::KP_MID_RST;
      kp_high_r <= gspi_pkg::KP_HIGH_RST;
      kp_low_r  <= gspi_pkg::KP_LOW_RST;
      ki_mid_r  <= gspi_pkg::KI_MID_RST;
      ki_high_r <= gspi_pkg::KI_HIGH_RST;
      ki_low_r  <= gspi_pkg::KI_LOW_RST;
      tw_r      <= gspi_pkg::TW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gspi_pkg::CFG_KP_MID:        kp_mid_r  <= cfg_wdata[gspi_pkg::KP_W-1:0];
        gspi_pkg::CFG_KP_HIGH:       kp_high_r <= cfg_wdata[gspi_pkg::KP_W-1:0];
        gspi_pkg::CFG_KP_LOW:        kp_low_r  <= cfg_wdata[gspi_pkg::KP_W-1:0];
        gspi_pkg::CFG_KI_MID:        ki_mid_r  <= cfg_wdata[gspi_pkg::KI_W-1:0];
        gspi_pkg::CFG_KI_HIGH:       ki_high_r <= cfg_wdata[gspi_pkg::KI_W-1:0];
        gspi_pkg::CFG_KI_LOW:        ki_low_r  <= cfg_wdata[gspi_pkg::KI_W-1:0];
        gspi_pkg::CFG_TARGET_WEIGHT: tw_r      <= cfg_wdata[gspi_pkg::TW_W-1:0];
        default: ;
      endcase
    end
  end

  // Speeds, range and integrators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= '0;
      measured_r <= '0;
      range_r    <= gspi_pkg::RANGE_MID;
      for (int i = 0; i < 3; i++) begin
        integ_r[i] <= '0;
      end
    end else begin
      if (ctl.in_load) begin
        unique case (in_command)
          gspi_pkg::CMD_SET_TARGET: begin
            target_r <= in_speed;
            range_r  <= range_pick;
          end
          gspi_pkg::CMD_SET_MEASURED: measured_r <= in_speed;
          default: ;
        endcase
      end
      if (ctl.step == gspi_pkg::ST_INTEG) begin
        for (int i = 0; i < 3; i++) begin
          integ_r[i] <= (2'(i) == rsel) ? integ_new : '0;
        end
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    if (ctl.in_load) begin
      ticks_r <= in_elapsed_ticks;
    end
    unique case (ctl.step)
      gspi_pkg::ST_MUL_TW: acc_r <= mul_p[ACC_W-1:0];
      gspi_pkg::ST_DIFF: begin
        errp_r <= acc_r[ERRP_W-1:0] - meas_q8;
        err_r  <= ERR_W'(target_r) - ERR_W'(measured_r);
      end
      gspi_pkg::ST_MUL_KP: p_r   <= mul_p[P_W-1:0];
      gspi_pkg::ST_MUL_KI: acc_r <= mul_p[ACC_W-1:0];
      gspi_pkg::ST_MUL_TK: acc_r <= mul_p[ACC_W-1:0];
      gspi_pkg::ST_SUM: begin
        x_r  <= X_W'(p_r) + X_W'(ih);
        fz_r <= (integ_sel[SH-1:0] == '0);
      end
      default: ;
    endcase
    if (ctl.out_load) begin
      drive_r    <= drv_clamped;
      gain_set_r <= range_r;
    end
  end

  assign out_drive    = drive_r;
  assign out_gain_set = gain_set_r;

endmodule

>>> rtl/gain_scheduled_pi_speed_controller_core.sv
// ----------------------------------------------------------------------------
// gain_scheduled_pi_speed_controller_core: gain-scheduled PI speed controller
// Stores target and measured speed, schedules one of three gain sets from the
// target and turns each compute command into one clamped drive value.
// ----------------------------------------------------------------------------
// Usage: send set-target (0) and set-measured (1) commands on in_ch; each is
// taken when the block is idle and gives no result. A compute command (2)
// is also taken when idle and then runs through eight steps of a
// sequencer around a single shared multiplier (target*alpha, error forming,
// kp product, ki product, ticks product, saturating integrator add, sum, and
// drive rounding), then the block is ready again. The drive result and the
// active gain set wait in an output register on out_ch, so the next command
// is taken while a result is still unclaimed; a compute only stalls in its
// last step if the previous result has not been taken yet. Command code 3 is
// dropped without effect. Write gains over cfg_* only while the block is
// idle; indexes 0..6 are kp_mid, kp_high, kp_low, ki_mid, ki_high, ki_low,
// target_weight, and higher indexes are ignored.
// ----------------------------------------------------------------------------
module gain_scheduled_pi_speed_controller_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gspi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gspi_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  gspi_in_if.sink                              in_ch,
  gspi_out_if.source                           out_ch
);

  // sequencer to datapath step control
  gspi_pkg::ctl_t ctl;

  // step sequencer: owns input ready and result valid
  gspi_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .ctl        (ctl)
  );

  // datapath: gains, state, shared multiplier and output register
  gspi_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_command       (in_ch.command),
    .in_speed         (in_ch.speed),
    .in_elapsed_ticks (in_ch.elapsed_ticks),
    .out_drive        (out_ch.drive),
    .out_gain_set     (out_ch.gain_set)
  );

endmodule

>>> tb/sv/gain_scheduled_pi_speed_controller_core_test.sv
// ----------------------------------------------------------------------------
// gain_scheduled_pi_speed_controller_core_test: self-checking bench of the core
// Sends speed and compute commands with random gaps, stalls the drive channel
// at random, and compares every drive word with a bit-exact speed loop model
// kept in the bench, across reset, extreme, fine and random gain settings.
// ----------------------------------------------------------------------------
module gain_scheduled_pi_speed_controller_core_test;
  import gspi_pkg::*;

  // Codes the package leaves unnamed: the spare command and the spare index.
  localparam logic [CMD_W-1:0]     CMD_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 3'd7;

  // Leave a margin for a compute to finish before gain writes and the end.
  localparam int     SETTLE_CYCLES = 16;
  localparam int     RANDOM_ITEMS  = 320;
  localparam int     RANDOM_PHASES = 8;
  localparam int     CLOSING_ITEMS = 100;
  localparam int     SAT_COMPUTES  = 2060;
  localparam int     TIMEOUT_UNITS = 4_000_000;
  localparam longint INTEG_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint INTEG_MIN     = -INTEG_MAX - 1;

  typedef enum int {
    GAINS_RESET,
    GAINS_ZERO,
    GAINS_FULL,
    GAINS_FINE,
    GAINS_RANDOM
  } gain_mode_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic [RANGE_W-1:0]        gain_set;
  } drive_word_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Idling on both channels follows this flag.
  bit gaps_on = 1'b1;
  int fault_count = 0;

  // Speed loop model: gains, stored speeds, integrators and scheduled range.
  logic [KP_W-1:0]           kp_gain [3];
  logic [KI_W-1:0]           ki_gain [3];
  logic [TW_W-1:0]           alpha_gain;
  logic signed [SPEED_W-1:0] target_rpm;
  logic signed [SPEED_W-1:0] measured_rpm;
  longint                    integ_acc [3];
  logic [RANGE_W-1:0]        sched_range;

  // Drive words still owed by the block, oldest first.
  drive_word_t drive_expected [$];

  gspi_in_if  in_ch ();
  gspi_out_if out_ch ();

  gain_scheduled_pi_speed_controller_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always #2 clk = ~clk;

  // Hard stop in case a transfer never completes.
  initial begin : watchdog
    #(TIMEOUT_UNITS);
    $display("gain_scheduled_pi_speed_controller_core: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what);
    fault_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  // Advance the model by one accepted command and queue the drive word that a
  // compute owes. Set commands only update state; the spare code does nothing.
  task automatic advance_speed_loop(input logic [CMD_W-1:0]        cmd,
                                    input logic signed [SPEED_W-1:0] rpm,
                                    input logic [TICKS_W-1:0]        ticks);
    longint      t_l, m_l, kp_l, ki_l, tw_l, tk_l;
    longint      err, err_w, prop, step, sum, ih, x, fl, drv;
    logic        ih_exact;
    int          r;
    drive_word_t word;
    case (cmd)
      CMD_SET_TARGET: begin
        // Schedule the gain set from the new target.
        if (rpm > SPD_HIGH_POS || rpm < SPD_HIGH_NEG) begin
          sched_range = RANGE_HIGH;
        end else if (rpm > SPD_MID_POS || rpm < SPD_MID_NEG) begin
          sched_range = RANGE_MID;
        end else begin
          sched_range = RANGE_LOW;
        end
        target_rpm = rpm;
      end
      CMD_SET_MEASURED: begin
        measured_rpm = rpm;
      end
      CMD_COMPUTE: begin
        r    = int'(sched_range);
        t_l  = target_rpm;
        m_l  = measured_rpm;
        kp_l = kp_gain[r];
        ki_l = ki_gain[r];
        tw_l = alpha_gain;
        tk_l = ticks;
        err   = t_l - m_l;
        err_w = t_l * tw_l - m_l * 256;
        prop  = kp_l * err_w;
        step  = ki_l * err * tk_l;
        // Saturate the integrator at the signed 64-bit limits.
        sum = integ_acc[r] + step;
        if (step > 0 && sum < integ_acc[r]) begin
          sum = INTEG_MAX;
        end else if (step < 0 && sum > integ_acc[r]) begin
          sum = INTEG_MIN;
        end
        // Only the active integrator survives a compute.
        for (int k = 0; k < 3; k++) begin
          integ_acc[k] = (k == r) ? sum : 64'sd0;
        end
        // Align the integrator to Q.16, keeping track of the dropped fraction
        // so the sum can be truncated toward zero exactly.
        ih       = sum >>> IH_SHIFT;
        ih_exact = (sum - (ih <<< IH_SHIFT)) == 0;
        x        = prop + ih;
        fl       = x >>> 16;
        if (fl < 0 && !(ih_exact && (x - (fl <<< 16)) == 0)) begin
          drv = fl + 1;
        end else begin
          drv = fl;
        end
        if (drv >= DRIVE_LIMIT) begin
          drv = DRIVE_LIMIT;
        end else if (drv <= -DRIVE_LIMIT) begin
          drv = -DRIVE_LIMIT;
        end
        word.drive    = drv[DRIVE_W-1:0];
        word.gain_set = sched_range;
        drive_expected.push_back(word);
      end
      default: ;
    endcase
  endtask

  // Send one command; valid stays high afterwards so back-to-back transfers
  // need no second assignment in the same step.
  task automatic send_item(input logic [CMD_W-1:0]        cmd,
                           input logic signed [SPEED_W-1:0] rpm,
                           input logic [TICKS_W-1:0]        ticks);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.speed         <= rpm;
    in_ch.elapsed_ticks <= ticks;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_speed_loop(cmd, rpm, ticks);
  endtask

  // Hold the sender until every owed drive word is in, then let the
  // sequencer run out before anything else happens.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all seven gain registers plus the spare index. Bits above a
  // register's width carry noise, which the block must drop.
  task automatic program_gains(input gain_mode_t mode);
    gain_mode_t            pick;
    int                    sel;
    logic [CFG_DATA_W-1:0] value;
    logic [CFG_DATA_W-1:0] keep;
    logic [CFG_IDX_W-1:0]  idx;
    for (int i = CFG_KP_MID; i <= CFG_SPARE; i++) begin
      idx  = CFG_IDX_W'(i);
      pick = mode;
      if (mode == GAINS_RANDOM) begin
        sel  = $urandom_range(GAINS_ZERO, GAINS_RANDOM + 1);
        pick = (sel >= GAINS_RANDOM) ? GAINS_RANDOM : gain_mode_t'(sel);
      end
      case (pick)
        GAINS_RESET: begin
          case (idx)
            CFG_KP_MID:        value = KP_MID_RST;
            CFG_KP_HIGH:       value = KP_HIGH_RST;
            CFG_KP_LOW:        value = KP_LOW_RST;
            CFG_KI_MID:        value = KI_MID_RST;
            CFG_KI_HIGH:       value = KI_HIGH_RST;
            CFG_KI_LOW:        value = KI_LOW_RST;
            CFG_TARGET_WEIGHT: value = TW_RST;
            default:           value = '0;
          endcase
        end
        GAINS_ZERO: value = '0;
        GAINS_FULL: value = '1;
        // Unit gains and unity weight: small, exactly predictable products.
        GAINS_FINE: value = (idx == CFG_TARGET_WEIGHT) ? CFG_DATA_W'(TW_RST)
                                                       : CFG_DATA_W'(1);
        // Random shift spreads values over small and large magnitudes.
        default:    value = CFG_DATA_W'($urandom >> $urandom_range(0, 31));
      endcase
      case (idx)
        CFG_KP_MID, CFG_KP_HIGH, CFG_KP_LOW: keep = CFG_DATA_W'({KP_W{1'b1}});
        CFG_KI_MID, CFG_KI_HIGH, CFG_KI_LOW: keep = '1;
        CFG_TARGET_WEIGHT:                   keep = CFG_DATA_W'({TW_W{1'b1}});
        default:                             keep = '0;
      endcase
      value = (value & keep) | (CFG_DATA_W'($urandom) & ~keep);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= value;
      @(posedge clk);
      case (idx)
        CFG_KP_MID, CFG_KP_HIGH, CFG_KP_LOW: kp_gain[idx - CFG_KP_MID] = value[KP_W-1:0];
        CFG_KI_MID, CFG_KI_HIGH, CFG_KI_LOW: ki_gain[idx - CFG_KI_MID] = value[KI_W-1:0];
        CFG_TARGET_WEIGHT:                   alpha_gain = value[TW_W-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Speeds: full range, just around a range threshold, the slow region,
  // or close to the current target so the drive does not always clamp.
  function automatic logic signed [SPEED_W-1:0] pick_rpm();
    logic signed [SPEED_W-1:0] base;
    case ($urandom_range(0, 3))
      0: return SPEED_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       base = SPD_HIGH_POS;
          1:       base = SPD_HIGH_NEG;
          2:       base = SPD_MID_POS;
          default: base = SPD_MID_NEG;
        endcase
        return SPEED_W'(int'(base) + int'($urandom_range(0, 4)) - 2);
      end
      2:       return SPEED_W'(int'($urandom_range(0, 600)) - 300);
      default: return SPEED_W'(int'(target_rpm) + int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  function automatic logic [TICKS_W-1:0] pick_ticks();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return TICKS_W'($urandom);
      default: return TICKS_W'($urandom_range(0, 1500));
    endcase
  endfunction

  // Mostly well-formed control sequences (set target, usually set measured,
  // then a few computes), with some lone commands and spare codes as noise.
  // Spare codes do not count toward the item budget.
  task automatic run_random(input int count, input bit hold_off);
    int sent;
    int n;
    bit held;
    sent = 0;
    held = 1'b0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          send_item(CMD_UNUSED, SPEED_W'($urandom), TICKS_W'($urandom));
        end else begin
          send_item(CMD_W'($urandom_range(CMD_SET_TARGET, CMD_COMPUTE)),
                    pick_rpm(), TICKS_W'($urandom));
          sent++;
        end
      end else begin
        send_item(CMD_SET_TARGET, pick_rpm(), TICKS_W'($urandom));
        sent++;
        if ($urandom_range(0, 3) != 0) begin
          send_item(CMD_SET_MEASURED, pick_rpm(), TICKS_W'($urandom));
          sent++;
        end
        n = $urandom_range(1, 4);
        repeat (n) send_item(CMD_COMPUTE, SPEED_W'($urandom), pick_ticks());
        sent += n;
      end
      // Pause the sender once until the block has handed over everything.
      if (hold_off && !held && sent >= count / 2) begin
        drain_results();
        held = 1'b1;
      end
    end
  endtask

  // Reset gains: zero state, every range threshold on both sides, the spare
  // command code, full-scale positive error, then zero error at -32768.
  task automatic test_directed_reset_gains();
    logic signed [SPEED_W-1:0] threshold_rpm [8];
    threshold_rpm = '{SPD_HIGH_POS, SPD_HIGH_POS + 16'sd1,
                      SPD_HIGH_NEG, SPD_HIGH_NEG - 16'sd1,
                      SPD_MID_POS,  SPD_MID_POS + 16'sd1,
                      SPD_MID_NEG,  SPD_MID_NEG - 16'sd1};
    send_item(CMD_COMPUTE, 16'sd0, 16'hFFFF);
    send_item(CMD_UNUSED, 16'sh7FFF, 16'hFFFF);
    send_item(CMD_SET_MEASURED, 16'sd100, 16'h0000);
    send_item(CMD_COMPUTE, -16'sd1, 16'h0000);
    foreach (threshold_rpm[i]) begin
      send_item(CMD_SET_TARGET, threshold_rpm[i], 16'h5555);
      send_item(CMD_COMPUTE, 16'shAAAA, 16'd500);
    end
    send_item(CMD_SET_TARGET, 16'sh7FFF, 16'h0000);
    send_item(CMD_SET_MEASURED, -16'sh8000, 16'hFFFF);
    send_item(CMD_COMPUTE, 16'sd0, 16'hFFFF);
    send_item(CMD_SET_TARGET, -16'sh8000, 16'h0000);
    send_item(CMD_COMPUTE, 16'sd0, 16'hFFFF);
  endtask

  // Zero gains, full-scale gains, then unit gains where the truncation
  // toward zero of exact and inexact negative sums is visible.
  task automatic test_gain_extremes();
    drain_results();
    program_gains(GAINS_ZERO);
    send_item(CMD_SET_TARGET, 16'sh7FFF, 16'h0000);
    send_item(CMD_SET_MEASURED, -16'sh8000, 16'h0000);
    send_item(CMD_COMPUTE, 16'sd0, 16'hFFFF);
    drain_results();
    program_gains(GAINS_FULL);
    send_item(CMD_COMPUTE, 16'sd0, 16'hFFFF);
    send_item(CMD_SET_TARGET, -16'sh8000, 16'h0000);
    send_item(CMD_COMPUTE, 16'sd0, 16'h0001);
    drain_results();
    program_gains(GAINS_FINE);
    send_item(CMD_SET_TARGET, 16'sd0, 16'h0000);
    send_item(CMD_SET_MEASURED, 16'sd256, 16'h0000);
    send_item(CMD_COMPUTE, 16'sd0, 16'h0000);
    send_item(CMD_SET_MEASURED, 16'sd255, 16'h0000);
    send_item(CMD_COMPUTE, 16'sd0, 16'h0000);
    send_item(CMD_SET_MEASURED, -16'sd256, 16'h0000);
    send_item(CMD_COMPUTE, 16'sd0, 16'h0000);
    send_item(CMD_SET_MEASURED, 16'sd255, 16'h0000);
    send_item(CMD_COMPUTE, 16'sd0, 16'h0001);
  endtask

  // Drive the high-range integrator into one of its 64-bit limits, picked at
  // random, with full gains and a full-scale error; a wrapping add would flip
  // the clamped drive sign.
  task automatic test_integrator_saturation();
    bit to_max;
    drain_results();
    program_gains(GAINS_FULL);
    gaps_on = ($urandom_range(0, 1) == 1);
    to_max  = ($urandom_range(0, 1) == 1);
    if (to_max) begin
      send_item(CMD_SET_TARGET, 16'sh7FFF, 16'h0000);
      send_item(CMD_SET_MEASURED, -16'sh8000, 16'h0000);
    end else begin
      send_item(CMD_SET_TARGET, -16'sh8000, 16'h0000);
      send_item(CMD_SET_MEASURED, 16'sh7FFF, 16'h0000);
    end
    repeat (SAT_COMPUTES) send_item(CMD_COMPUTE, 16'sd0, 16'hFFFF);
    // A low-range compute clears the saturated integrator.
    send_item(CMD_SET_TARGET, 16'sd0, 16'h0000);
    send_item(CMD_COMPUTE, 16'sd0, 16'h0010);
    gaps_on = 1'b1;
  endtask

  // Random phases, each with fresh gains; idling alternates per phase and
  // one phase holds the sender until the block has drained.
  task automatic test_random_phases();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      program_gains((ph == 0) ? GAINS_RESET : GAINS_RANDOM);
      gaps_on = ((ph % 2) == 0);
      run_random(RANDOM_ITEMS / RANDOM_PHASES, ph == 3);
    end
  endtask

  // Closing stretch at full rate: no sender gaps, no receiver stalls.
  task automatic test_back_to_back();
    drain_results();
    program_gains(GAINS_RANDOM);
    gaps_on = 1'b0;
    run_random(CLOSING_ITEMS, 1'b0);
  endtask

  // Drive channel sink: accept at random with stall bursts while idling is on.
  initial begin : drive_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each drive transfer with the oldest owed word, field by field.
  always @(posedge clk) begin : check_drive
    drive_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (drive_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected drive %0d gain_set %0d",
                                  out_ch.drive, out_ch.gain_set));
      end else begin
        want = drive_expected.pop_front();
        if (out_ch.drive !== want.drive) begin
          report_mismatch($sformatf("drive %0d, want %0d", out_ch.drive, want.drive));
        end
        if (out_ch.gain_set !== want.gain_set) begin
          report_mismatch($sformatf("gain_set %0d, want %0d",
                                    out_ch.gain_set, want.gain_set));
        end
      end
    end
  end

  initial begin : run_tests
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_SET_TARGET;
    in_ch.speed         <= '0;
    in_ch.elapsed_ticks <= '0;
    // Model state after reset.
    kp_gain      = '{KP_MID_RST, KP_HIGH_RST, KP_LOW_RST};
    ki_gain      = '{KI_MID_RST, KI_HIGH_RST, KI_LOW_RST};
    alpha_gain   = TW_RST;
    target_rpm   = '0;
    measured_rpm = '0;
    integ_acc    = '{64'sd0, 64'sd0, 64'sd0};
    sched_range  = RANGE_MID;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_reset_gains();
    test_gain_extremes();
    test_integrator_saturation();
    test_random_phases();
    test_back_to_back();

    drain_results();
    if (drive_expected.size() != 0) begin
      report_mismatch($sformatf("%0d drive words never arrived", drive_expected.size()));
    end
    if (fault_count == 0) begin
      $display("gain_scheduled_pi_speed_controller_core: match");
    end else begin
      $display("gain_scheduled_pi_speed_controller_core: mismatch");
    end
    $finish;
  end

endmodule
